>>> sv/botp_pkg.sv
package botp_pkg;

   localparam int AXIS_N  = 3;
   localparam int COORD_W = 16;
   localparam int IDX_W   = 8;
   localparam int NODE_W  = 16;
   localparam int SLOT_W  = 16;
   localparam int TOTAL_W = 63;
   localparam int VOL_W   = 48;
   localparam int PROD_W  = 32;

   localparam logic [1:0] OP_LOAD_SRC = 2'd0;
   localparam logic [1:0] OP_LOAD_DST = 2'd1;
   localparam logic [1:0] OP_QUERY    = 2'd2;
   localparam logic [1:0] OP_CLEAR    = 2'd3;

   localparam logic KIND_SEND = 1'b0;
   localparam logic KIND_RECV = 1'b1;

   localparam logic [SLOT_W-1:0]  SLOT_MAX  = '1;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   typedef logic [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type [AXIS_N-1:0] start;
      coord_type [AXIS_N-1:0] size;
      logic [NODE_W-1:0]      owner;
   } box_type;

   // one queued job for the back end: a query with both boxes, or a clear
   typedef struct packed {
      logic             is_clear;
      logic [IDX_W-1:0] src_idx;
      logic [IDX_W-1:0] dst_idx;
      box_type          src;
      box_type          dst;
   } item_type;

endpackage

>>> sv/botp_ram.sv
module botp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/botp_front.sv
module botp_front import botp_pkg::*; #(
   parameter int MAX_REGIONS = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_operation,
   input  logic [IDX_W-1:0]   req_entry_index,
   input  logic [COORD_W-1:0] req_start_x,
   input  logic [COORD_W-1:0] req_start_y,
   input  logic [COORD_W-1:0] req_start_z,
   input  logic [COORD_W-1:0] req_size_x,
   input  logic [COORD_W-1:0] req_size_y,
   input  logic [COORD_W-1:0] req_size_z,
   input  logic [NODE_W-1:0]  req_owner,
   input  logic [IDX_W-1:0]   req_dest_index,
   input  logic [IDX_W-1:0]   req_source_index,
   output logic               q_push,
   output item_type           q_item,
   input  logic               q_full
);

   localparam int AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int BOX_W = $bits(box_type);

   logic             accept;
   logic             entry_ok;
   logic             query_ok;
   logic             src_wr;
   logic             dst_wr;
   logic             clear_go;
   box_type          load_box;
   logic [BOX_W-1:0] src_rd_data;
   logic [BOX_W-1:0] dst_rd_data;

   logic             s1_valid_ff, s1_valid_in;
   logic             s1_clear_ff, s1_clear_in;
   logic [IDX_W-1:0] s1_src_idx_ff, s1_src_idx_in;
   logic [IDX_W-1:0] s1_dst_idx_ff, s1_dst_idx_in;

   // a held job in the read stage blocks new beats only while the queue is full
   assign req_stall = s1_valid_ff & q_full;
   assign accept    = req_valid & ~req_stall;
   assign q_push    = s1_valid_ff & ~q_full;

   assign entry_ok = 32'(req_entry_index) < 32'(MAX_REGIONS);
   assign src_wr   = accept && (req_operation == OP_LOAD_SRC) && entry_ok;
   assign dst_wr   = accept && (req_operation == OP_LOAD_DST) && entry_ok;
   assign query_ok = accept && (req_operation == OP_QUERY)
                     && (32'(req_dest_index) < 32'(MAX_REGIONS))
                     && (32'(req_source_index) < 32'(MAX_REGIONS));
   assign clear_go = accept && (req_operation == OP_CLEAR);

   always_comb begin
      load_box.start[0] = req_start_x;
      load_box.start[1] = req_start_y;
      load_box.start[2] = req_start_z;
      load_box.size[0]  = req_size_x;
      load_box.size[1]  = req_size_y;
      load_box.size[2]  = req_size_z;
      load_box.owner    = req_owner;
   end

   botp_ram #(
      .WIDTH (BOX_W),
      .DEPTH (MAX_REGIONS)
   ) u_src_ram (
      .clock   (clock),
      .wr_en   (src_wr),
      .wr_addr (AW'(req_entry_index)),
      .wr_data (load_box),
      .rd_en   (query_ok),
      .rd_addr (AW'(req_source_index)),
      .rd_data (src_rd_data)
   );

   botp_ram #(
      .WIDTH (BOX_W),
      .DEPTH (MAX_REGIONS)
   ) u_dst_ram (
      .clock   (clock),
      .wr_en   (dst_wr),
      .wr_addr (AW'(req_entry_index)),
      .wr_data (load_box),
      .rd_en   (query_ok),
      .rd_addr (AW'(req_dest_index)),
      .rd_data (dst_rd_data)
   );

   always_comb begin
      s1_valid_in   = s1_valid_ff;
      s1_clear_in   = s1_clear_ff;
      s1_src_idx_in = s1_src_idx_ff;
      s1_dst_idx_in = s1_dst_idx_ff;
      if (q_push) begin
         s1_valid_in = 1'b0;
      end
      if (query_ok || clear_go) begin
         s1_valid_in   = 1'b1;
         s1_clear_in   = clear_go;
         s1_src_idx_in = req_source_index;
         s1_dst_idx_in = req_dest_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_clear_ff   <= s1_clear_in;
      s1_src_idx_ff <= s1_src_idx_in;
      s1_dst_idx_ff <= s1_dst_idx_in;
   end

   always_comb begin
      q_item.is_clear = s1_clear_ff;
      q_item.src_idx  = s1_src_idx_ff;
      q_item.dst_idx  = s1_dst_idx_ff;
      q_item.src      = src_rd_data;
      q_item.dst      = dst_rd_data;
   end

endmodule

>>> sv/botp_queue.sv
module botp_queue import botp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output item_type pop_item,
   output logic     empty
);

   localparam int QDEPTH = 2;
   localparam int PW = $clog2(QDEPTH);

   item_type          slot_ff [QDEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PW:0]       count_ff, count_in;

   assign full     = count_ff == (PW+1)'(QDEPTH);
   assign empty    = count_ff == '0;
   assign pop_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> sv/botp_back.sv
module botp_back import botp_pkg::*; #(
   parameter int AXES = 3
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [NODE_W-1:0]  my_node,
   input  logic               q_empty,
   output logic               q_pop,
   input  item_type           q_item,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_record_kind,
   output logic [SLOT_W-1:0]  rsp_slot,
   output logic [COORD_W-1:0] rsp_rel_start_x,
   output logic [COORD_W-1:0] rsp_rel_start_y,
   output logic [COORD_W-1:0] rsp_rel_start_z,
   output logic [COORD_W-1:0] rsp_extent_x,
   output logic [COORD_W-1:0] rsp_extent_y,
   output logic [COORD_W-1:0] rsp_extent_z,
   output logic [IDX_W-1:0]   rsp_partner,
   output logic [TOTAL_W-1:0] rsp_send_volume_total,
   output logic [TOTAL_W-1:0] rsp_receive_volume_total,
   output logic               rsp_last
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_AXES = 3'd1;
   localparam logic [2:0] ST_MUL1 = 3'd2;
   localparam logic [2:0] ST_MUL2 = 3'd3;
   localparam logic [2:0] ST_ACC  = 3'd4;
   localparam logic [2:0] ST_SEND = 3'd5;
   localparam logic [2:0] ST_RECV = 3'd6;

   coord_type [AXIS_N-1:0] ext_c, rs_c, rr_c;

   logic [2:0]             state_ff, state_in;
   item_type               item_ff, item_in;
   coord_type [AXIS_N-1:0] ext_ff, ext_in;
   coord_type [AXIS_N-1:0] rs_ff, rs_in;
   coord_type [AXIS_N-1:0] rr_ff, rr_in;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic [VOL_W-1:0]       vol_ff, vol_in;
   logic                   do_recv_ff, do_recv_in;
   logic [SLOT_W-1:0]      sslot_ff, sslot_in;
   logic [SLOT_W-1:0]      rslot_ff, rslot_in;
   logic [SLOT_W-1:0]      send_count_ff, send_count_in;
   logic [SLOT_W-1:0]      recv_count_ff, recv_count_in;
   logic [TOTAL_W-1:0]     send_total_ff, send_total_in;
   logic [TOTAL_W-1:0]     recv_total_ff, recv_total_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_kind_ff, rsp_kind_in;
   logic [SLOT_W-1:0]      rsp_slot_ff, rsp_slot_in;
   coord_type [AXIS_N-1:0] rsp_rel_ff, rsp_rel_in;
   coord_type [AXIS_N-1:0] rsp_ext_ff, rsp_ext_in;
   logic [IDX_W-1:0]       rsp_partner_ff, rsp_partner_in;
   logic [TOTAL_W-1:0]     rsp_send_total_ff, rsp_send_total_in;
   logic [TOTAL_W-1:0]     rsp_recv_total_ff, rsp_recv_total_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   send_hit;
   logic                   recv_hit;
   logic                   rsp_free;
   logic [TOTAL_W:0]       send_sum;
   logic [TOTAL_W:0]       recv_sum;

   // per-axis intersection: larger start to smaller end, ends kept at 17 bits; unused axes give extent 1
   genvar a;
   generate
      for (a = 0; a < AXIS_N; a++) begin : g_axis
         if (a < AXES) begin : g_used
            logic [COORD_W:0]   src_end, dst_end, hi;
            logic [COORD_W-1:0] lo;
            logic               hit;
            assign src_end = {1'b0, item_ff.src.start[a]} + {1'b0, item_ff.src.size[a]};
            assign dst_end = {1'b0, item_ff.dst.start[a]} + {1'b0, item_ff.dst.size[a]};
            assign lo  = (item_ff.src.start[a] > item_ff.dst.start[a]) ?
                         item_ff.src.start[a] : item_ff.dst.start[a];
            assign hi  = (src_end < dst_end) ? src_end : dst_end;
            assign hit = hi > {1'b0, lo};
            assign ext_c[a] = hit ? COORD_W'(hi - {1'b0, lo}) : '0;
            assign rs_c[a]  = hit ? lo - item_ff.src.start[a] : '0;
            assign rr_c[a]  = hit ? lo - item_ff.dst.start[a] : '0;
         end else begin : g_unused
            assign ext_c[a] = COORD_W'(1);
            assign rs_c[a]  = '0;
            assign rr_c[a]  = '0;
         end
      end
   endgenerate

   assign send_hit = item_ff.src.owner == my_node;
   assign recv_hit = item_ff.dst.owner == my_node;
   assign send_sum = {1'b0, send_total_ff} + (TOTAL_W+1)'(vol_ff);
   assign recv_sum = {1'b0, recv_total_ff} + (TOTAL_W+1)'(vol_ff);
   assign rsp_free = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      state_in          = state_ff;
      item_in           = item_ff;
      ext_in            = ext_ff;
      rs_in             = rs_ff;
      rr_in             = rr_ff;
      prod_in           = prod_ff;
      vol_in            = vol_ff;
      do_recv_in        = do_recv_ff;
      sslot_in          = sslot_ff;
      rslot_in          = rslot_ff;
      send_count_in     = send_count_ff;
      recv_count_in     = recv_count_ff;
      send_total_in     = send_total_ff;
      recv_total_in     = recv_total_ff;
      rsp_valid_in      = rsp_valid_ff;
      rsp_kind_in       = rsp_kind_ff;
      rsp_slot_in       = rsp_slot_ff;
      rsp_rel_in        = rsp_rel_ff;
      rsp_ext_in        = rsp_ext_ff;
      rsp_partner_in    = rsp_partner_ff;
      rsp_send_total_in = rsp_send_total_ff;
      rsp_recv_total_in = rsp_recv_total_ff;
      rsp_last_in       = rsp_last_ff;
      q_pop             = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               if (q_item.is_clear) begin
                  send_count_in = '0;
                  recv_count_in = '0;
                  send_total_in = '0;
                  recv_total_in = '0;
               end else begin
                  item_in  = q_item;
                  state_in = ST_AXES;
               end
            end
         end
         ST_AXES: begin
            ext_in   = ext_c;
            rs_in    = rs_c;
            rr_in    = rr_c;
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            prod_in  = PROD_W'(ext_ff[0]) * PROD_W'(ext_ff[1]);
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            vol_in   = VOL_W'(prod_ff) * VOL_W'(ext_ff[2]);
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if ((vol_ff == '0) || (!send_hit && !recv_hit)) begin
               state_in = ST_IDLE;
            end else begin
               do_recv_in = recv_hit;
               if (send_hit) begin
                  sslot_in = send_count_ff;
                  if (send_count_ff != SLOT_MAX) begin
                     send_count_in = send_count_ff + 1'b1;
                  end
                  send_total_in = send_sum[TOTAL_W] ? TOTAL_MAX : send_sum[TOTAL_W-1:0];
               end
               if (recv_hit) begin
                  rslot_in = recv_count_ff;
                  if (recv_count_ff != SLOT_MAX) begin
                     recv_count_in = recv_count_ff + 1'b1;
                  end
                  recv_total_in = recv_sum[TOTAL_W] ? TOTAL_MAX : recv_sum[TOTAL_W-1:0];
               end
               state_in = send_hit ? ST_SEND : ST_RECV;
            end
         end
         ST_SEND: begin
            if (rsp_free) begin
               rsp_valid_in      = 1'b1;
               rsp_kind_in       = KIND_SEND;
               rsp_slot_in       = sslot_ff;
               rsp_rel_in        = rs_ff;
               rsp_ext_in        = ext_ff;
               rsp_partner_in    = item_ff.src_idx;
               rsp_send_total_in = send_total_ff;
               rsp_recv_total_in = recv_total_ff;
               rsp_last_in       = ~do_recv_ff;
               state_in          = do_recv_ff ? ST_RECV : ST_IDLE;
            end
         end
         ST_RECV: begin
            if (rsp_free) begin
               rsp_valid_in      = 1'b1;
               rsp_kind_in       = KIND_RECV;
               rsp_slot_in       = rslot_ff;
               rsp_rel_in        = rr_ff;
               rsp_ext_in        = ext_ff;
               rsp_partner_in    = item_ff.dst_idx;
               rsp_send_total_in = send_total_ff;
               rsp_recv_total_in = recv_total_ff;
               rsp_last_in       = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         send_count_ff <= '0;
         recv_count_ff <= '0;
         send_total_ff <= '0;
         recv_total_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         send_count_ff <= send_count_in;
         recv_count_ff <= recv_count_in;
         send_total_ff <= send_total_in;
         recv_total_ff <= recv_total_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff           <= item_in;
      ext_ff            <= ext_in;
      rs_ff             <= rs_in;
      rr_ff             <= rr_in;
      prod_ff           <= prod_in;
      vol_ff            <= vol_in;
      do_recv_ff        <= do_recv_in;
      sslot_ff          <= sslot_in;
      rslot_ff          <= rslot_in;
      rsp_kind_ff       <= rsp_kind_in;
      rsp_slot_ff       <= rsp_slot_in;
      rsp_rel_ff        <= rsp_rel_in;
      rsp_ext_ff        <= rsp_ext_in;
      rsp_partner_ff    <= rsp_partner_in;
      rsp_send_total_ff <= rsp_send_total_in;
      rsp_recv_total_ff <= rsp_recv_total_in;
      rsp_last_ff       <= rsp_last_in;
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_record_kind          = rsp_kind_ff;
   assign rsp_slot                 = rsp_slot_ff;
   assign rsp_rel_start_x          = rsp_rel_ff[0];
   assign rsp_rel_start_y          = rsp_rel_ff[1];
   assign rsp_rel_start_z          = rsp_rel_ff[2];
   assign rsp_extent_x             = rsp_ext_ff[0];
   assign rsp_extent_y             = rsp_ext_ff[1];
   assign rsp_extent_z             = rsp_ext_ff[2];
   assign rsp_partner              = rsp_partner_ff;
   assign rsp_send_volume_total    = rsp_send_total_ff;
   assign rsp_receive_volume_total = rsp_recv_total_ff;
   assign rsp_last                 = rsp_last_ff;

endmodule

>>> sv/box_overlap_transfer_planner.sv
// loads, queries and clears are taken one per cycle while req_stall is low; a query or clear also waits for a
// free slot in the two-entry job queue between the table front end and the back end
// the back end is a sequencer (intersect, two multiplies, total update, emit) that takes
// one job from the queue at a time and emits none, one or two records for a query
// synchronous reset clears counters, totals, my_node and all handshake state; tables are not cleared
module box_overlap_transfer_planner import botp_pkg::*; #(
   parameter int MAX_REGIONS = 256,
   parameter int AXES        = 3
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [NODE_W-1:0]  csr_wr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_operation,
   input  logic [IDX_W-1:0]   req_entry_index,
   input  logic [COORD_W-1:0] req_start_x,
   input  logic [COORD_W-1:0] req_start_y,
   input  logic [COORD_W-1:0] req_start_z,
   input  logic [COORD_W-1:0] req_size_x,
   input  logic [COORD_W-1:0] req_size_y,
   input  logic [COORD_W-1:0] req_size_z,
   input  logic [NODE_W-1:0]  req_owner,
   input  logic [IDX_W-1:0]   req_dest_index,
   input  logic [IDX_W-1:0]   req_source_index,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_record_kind,
   output logic [SLOT_W-1:0]  rsp_slot,
   output logic [COORD_W-1:0] rsp_rel_start_x,
   output logic [COORD_W-1:0] rsp_rel_start_y,
   output logic [COORD_W-1:0] rsp_rel_start_z,
   output logic [COORD_W-1:0] rsp_extent_x,
   output logic [COORD_W-1:0] rsp_extent_y,
   output logic [COORD_W-1:0] rsp_extent_z,
   output logic [IDX_W-1:0]   rsp_partner,
   output logic [TOTAL_W-1:0] rsp_send_volume_total,
   output logic [TOTAL_W-1:0] rsp_receive_volume_total,
   output logic               rsp_last
);

   logic [NODE_W-1:0] my_node_ff, my_node_in;
   logic              q_push;
   logic              q_full;
   logic              q_pop;
   logic              q_empty;
   item_type          q_push_item;
   item_type          q_pop_item;

   assign my_node_in = csr_wr_en ? csr_wr_data : my_node_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         my_node_ff <= '0;
      end else begin
         my_node_ff <= my_node_in;
      end
   end

   botp_front #(
      .MAX_REGIONS (MAX_REGIONS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_entry_index  (req_entry_index),
      .req_start_x      (req_start_x),
      .req_start_y      (req_start_y),
      .req_start_z      (req_start_z),
      .req_size_x       (req_size_x),
      .req_size_y       (req_size_y),
      .req_size_z       (req_size_z),
      .req_owner        (req_owner),
      .req_dest_index   (req_dest_index),
      .req_source_index (req_source_index),
      .q_push           (q_push),
      .q_item           (q_push_item),
      .q_full           (q_full)
   );

   botp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (q_pop_item),
      .empty     (q_empty)
   );

   botp_back #(
      .AXES (AXES)
   ) u_back (
      .clock                    (clock),
      .reset                    (reset),
      .my_node                  (my_node_ff),
      .q_empty                  (q_empty),
      .q_pop                    (q_pop),
      .q_item                   (q_pop_item),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_record_kind          (rsp_record_kind),
      .rsp_slot                 (rsp_slot),
      .rsp_rel_start_x          (rsp_rel_start_x),
      .rsp_rel_start_y          (rsp_rel_start_y),
      .rsp_rel_start_z          (rsp_rel_start_z),
      .rsp_extent_x             (rsp_extent_x),
      .rsp_extent_y             (rsp_extent_y),
      .rsp_extent_z             (rsp_extent_z),
      .rsp_partner              (rsp_partner),
      .rsp_send_volume_total    (rsp_send_volume_total),
      .rsp_receive_volume_total (rsp_receive_volume_total),
      .rsp_last                 (rsp_last)
   );

endmodule
